FILE: hdl/source_text_tokenizer_assert.svh
// ---------------------------------------------------------------------------
// source_text_tokenizer_assert
// Assertion helpers for the tokenizer RTL.
// Each use expands to one labeled concurrent assertion on clk_i, muted during reset.
// ---------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/stt_pkg.sv
// ---------------------------------------------------------------------------
// stt_pkg
// Types, widths, character codes and byte classes shared by the tokenizer.
// ---------------------------------------------------------------------------
package stt_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_IDENT    = 4'd1,
    M_NUMBER   = 4'd2,
    M_STRING   = 4'd3,
    M_ISTRING  = 4'd4,
    M_PENDING  = 4'd5,
    M_LCOMMENT = 4'd6,
    M_BCOMMENT = 4'd7,
    M_BSTAR    = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    K_IDENT   = 3'd0,
    K_NUMBER  = 3'd1,
    K_STRING  = 3'd2,
    K_ISTRING = 3'd3,
    K_SYMBOL  = 3'd4,
    K_EOF     = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   fin;
  } res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
  endfunction

  function automatic logic is_lookahead(input logic [7:0] c);
    return c == CH_SLASH || c == CH_DOLLAR || c == CH_EQ || c == CH_BANG ||
           c == CH_LT || c == CH_GT || c == CH_AMP || c == CH_PIPE ||
           c == CH_PLUS || c == CH_MINUS;
  endfunction

endpackage

FILE: hdl/stt_intf.sv
// ---------------------------------------------------------------------------
// stt_in_if / stt_out_if
// Valid/ready channels for source bytes in and token descriptors out.
// ---------------------------------------------------------------------------
interface stt_in_if import stt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface stt_out_if import stt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             token_kind;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [OFFSET_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   token_line;
  logic [COLUMN_BITS-1:0] start_column;
  logic                   final_token;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output token_line, output start_column,
                  output final_token, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input token_line, input start_column,
                  input final_token, output ready);
endinterface

FILE: hdl/source_text_tokenizer.sv
// ---------------------------------------------------------------------------
// source_text_tokenizer
// Streaming C-like lexer: source bytes in, token descriptors out.
// ---------------------------------------------------------------------------
//  channel | dir | beat
//  src_i   | in  | one source byte, or the end-of-text marker
//  tok_o   | out | one token descriptor (kind, offset, length, line, column)
//
//  One byte per cycle while src_i.ready is high: the scan state updates in a single pass per beat.
//  A beat makes up to two descriptors, held in a three-entry output queue;
//  src_i.ready is high while the queue holds at most one entry.
//  Output stalls therefore stop input after at most two more beats.
//  Reset returns the scanner to line 1, column 1, offset 0, queue empty.
// ---------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module source_text_tokenizer import stt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    src_i,
  stt_out_if.source tok_o
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

  // scan state
  mode_e                  mode_q, mode_d;
  logic [7:0]             pend_q, pend_d;
  logic [7:0]             prev_q, prev_d;
  logic [7:0]             quote_q, quote_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [OFFSET_BITS-1:0] ts_off_q, ts_off_d;
  logic [LINE_BITS-1:0]   ts_line_q, ts_line_d;
  logic [COLUMN_BITS-1:0] ts_col_q, ts_col_d;

  // output queue
  res_t       que_q [3];
  res_t       que_d [3];
  logic [1:0] cnt_q, cnt_d;

  logic       acc, pop, eot;
  logic [7:0] c;

  logic [OFFSET_BITS-1:0] off_inc, len_cur, len_next;
  logic [LINE_BITS-1:0]   line_inc;
  logic [COLUMN_BITS-1:0] col_inc;

  // between-token handling of the current byte
  mode_e                  idle_mode;
  logic [LINE_BITS-1:0]   idle_line;
  logic [COLUMN_BITS-1:0] idle_col;
  logic                   idle_mark, idle_emit, idle_quote, idle_pend;

  logic                   use_idle;
  logic                   va, vb;
  kind_e                  a_kind;
  logic [OFFSET_BITS-1:0] a_len;
  res_t                   res_a, res_b, first;
  logic [1:0]             base, npush;

  assign acc = src_i.valid && src_i.ready;
  assign pop = tok_o.valid && tok_o.ready;
  assign eot = src_i.end_of_text;
  assign c   = src_i.text_byte;

  assign src_i.ready = (cnt_q <= 2'd1);

  assign off_inc  = (off_q == OFF_MAX) ? off_q : off_q + OFFSET_BITS'(1);
  assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + LINE_BITS'(1);
  assign col_inc  = (col_q == COL_MAX) ? col_q : col_q + COLUMN_BITS'(1);
  assign len_cur  = (off_q >= ts_off_q) ? off_q - ts_off_q : '0;
  assign len_next = (off_inc >= ts_off_q) ? off_inc - ts_off_q : '0;

  always_comb begin
    idle_mode  = M_IDLE;
    idle_line  = line_q;
    idle_col   = col_q;
    idle_mark  = 1'b0;
    idle_emit  = 1'b0;
    idle_quote = 1'b0;
    idle_pend  = 1'b0;
    if (c == CH_CR) begin
      idle_mode = M_IDLE;
    end else if (c == CH_LF) begin
      idle_line = line_inc;
      idle_col  = COL_ONE;
    end else if (is_blank(c)) begin
      idle_col = col_inc;
    end else begin
      idle_mark = 1'b1;
      idle_col  = col_inc;
      if (is_alpha(c) || c == CH_UNDER) begin
        idle_mode = M_IDENT;
      end else if (is_digit(c)) begin
        idle_mode = M_NUMBER;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        idle_mode  = M_STRING;
        idle_quote = 1'b1;
      end else if (is_lookahead(c)) begin
        idle_mode = M_PENDING;
        idle_pend = 1'b1;
      end else begin
        idle_emit = 1'b1;
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    pend_d    = pend_q;
    prev_d    = prev_q;
    quote_d   = quote_q;
    off_d     = off_q;
    line_d    = line_q;
    col_d     = col_q;
    ts_off_d  = ts_off_q;
    ts_line_d = ts_line_q;
    ts_col_d  = ts_col_q;
    use_idle  = 1'b0;
    va        = 1'b0;
    vb        = 1'b0;
    a_kind    = K_SYMBOL;
    a_len     = len_cur;

    if (acc && eot) begin
      case (mode_q)
        M_IDENT: begin
          va = 1'b1;
          a_kind = K_IDENT;
        end
        M_NUMBER: begin
          va = 1'b1;
          a_kind = K_NUMBER;
        end
        M_STRING: begin
          va = 1'b1;
          a_kind = K_STRING;
        end
        M_ISTRING: begin
          va = 1'b1;
          a_kind = K_ISTRING;
        end
        M_PENDING: begin
          va = 1'b1;
          a_kind = K_SYMBOL;
          a_len = OFFSET_BITS'(1);
        end
        default: va = 1'b0;
      endcase
      vb        = 1'b1;
      mode_d    = M_IDLE;
      pend_d    = '0;
      prev_d    = '0;
      quote_d   = '0;
      off_d     = '0;
      line_d    = LINE_ONE;
      col_d     = COL_ONE;
      ts_off_d  = '0;
      ts_line_d = LINE_ONE;
      ts_col_d  = COL_ONE;
    end else if (acc) begin
      case (mode_q)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            col_d = col_inc;
          end else begin
            va = 1'b1;
            a_kind = K_IDENT;
            use_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c) || c == CH_DOT) begin
            col_d = col_inc;
          end else begin
            va = 1'b1;
            a_kind = K_NUMBER;
            use_idle = 1'b1;
          end
        end
        M_STRING, M_ISTRING: begin
          if (c == quote_q && prev_q != CH_BSLASH) begin
            col_d  = col_inc;
            va     = 1'b1;
            a_kind = (mode_q == M_STRING) ? K_STRING : K_ISTRING;
            a_len  = len_next;
            mode_d = M_IDLE;
          end else if (c == CH_LF) begin
            line_d = line_inc;
            col_d  = COL_ONE;
          end else begin
            col_d = col_inc;
          end
        end
        M_PENDING: begin
          if (pend_q == CH_SLASH && c == CH_SLASH) begin
            col_d  = ts_col_q;      // line comment puts the column back to that of the first slash
            mode_d = M_LCOMMENT;
          end else if (pend_q == CH_SLASH && c == CH_STAR) begin
            col_d  = col_inc;
            mode_d = M_BCOMMENT;
          end else if (pend_q == CH_DOLLAR && c == CH_DQUOTE) begin
            col_d   = col_inc;
            quote_d = CH_DQUOTE;
            mode_d  = M_ISTRING;
          end else if (((pend_q == CH_EQ || pend_q == CH_BANG || pend_q == CH_LT ||
                         pend_q == CH_GT) && c == CH_EQ) ||
                       ((pend_q == CH_AMP || pend_q == CH_PIPE || pend_q == CH_PLUS ||
                         pend_q == CH_MINUS) && c == pend_q)) begin
            col_d  = col_inc;
            va     = 1'b1;
            a_len  = OFFSET_BITS'(2);
            mode_d = M_IDLE;
          end else begin
            va       = 1'b1;
            a_len    = OFFSET_BITS'(1);
            use_idle = 1'b1;
          end
        end
        M_LCOMMENT: begin
          use_idle = (c == CH_LF);
        end
        M_BCOMMENT, M_BSTAR: begin
          if (c == CH_LF) begin
            line_d = line_inc;
            col_d  = COL_ONE;
          end else begin
            col_d = col_inc;
          end
          if (mode_q == M_BCOMMENT) begin
            if (c == CH_STAR) mode_d = M_BSTAR;
          end else if (c == CH_SLASH) begin
            mode_d = M_IDLE;
          end else if (c != CH_STAR) begin
            mode_d = M_BCOMMENT;
          end
        end
        default: use_idle = 1'b1;
      endcase

      if (use_idle) begin
        mode_d = idle_mode;
        line_d = idle_line;
        col_d  = idle_col;
        vb     = idle_emit;
        if (idle_mark) begin
          ts_off_d  = off_q;
          ts_line_d = line_q;
          ts_col_d  = col_q;
        end
        if (idle_quote) quote_d = c;
        if (idle_pend)  pend_d  = c;
      end
      prev_d = c;
      off_d  = off_inc;
    end
  end

  // token that was open before this beat
  always_comb begin
    res_a.kind = a_kind;
    res_a.off  = ts_off_q;
    res_a.len  = a_len;
    res_a.line = ts_line_q;
    res_a.col  = ts_col_q;
    res_a.fin  = 1'b0;
  end

  // one-byte symbol at the current byte, or the EOF marker
  always_comb begin
    res_b.kind = eot ? K_EOF : K_SYMBOL;
    res_b.off  = off_q;
    res_b.len  = eot ? '0 : OFFSET_BITS'(1);
    res_b.line = line_q;
    res_b.col  = col_q;
    res_b.fin  = eot;
  end

  assign first = va ? res_a : res_b;
  assign npush = {1'b0, va} + {1'b0, vb};
  assign base  = cnt_q - {1'b0, pop};

  always_comb begin
    que_d = que_q;
    if (pop) begin
      que_d[0] = que_q[1];
      que_d[1] = que_q[2];
    end
    for (int i = 0; i < 3; i++) begin
      if ((va || vb) && base == 2'(i)) que_d[i] = first;
      if (va && vb && base + 2'd1 == 2'(i)) que_d[i] = res_b;
    end
    cnt_d = cnt_q - {1'b0, pop} + npush;
  end

  always_ff @(posedge clk_i) begin
    que_q <= que_d;
    pend_q <= pend_d;
    prev_q <= prev_d;
    quote_q <= quote_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      mode_q    <= M_IDLE;
      off_q     <= '0;
      line_q    <= LINE_ONE;
      col_q     <= COL_ONE;
      ts_off_q  <= '0;
      ts_line_q <= LINE_ONE;
      ts_col_q  <= COL_ONE;
    end else begin
      cnt_q     <= cnt_d;
      mode_q    <= mode_d;
      off_q     <= off_d;
      line_q    <= line_d;
      col_q     <= col_d;
      ts_off_q  <= ts_off_d;
      ts_line_q <= ts_line_d;
      ts_col_q  <= ts_col_d;
    end
  end

  assign tok_o.valid        = (cnt_q != 2'd0);
  assign tok_o.token_kind   = que_q[0].kind;
  assign tok_o.start_offset = que_q[0].off;
  assign tok_o.token_length = que_q[0].len;
  assign tok_o.token_line   = que_q[0].line;
  assign tok_o.start_column = que_q[0].col;
  assign tok_o.final_token  = que_q[0].fin;

  `STT_ASSERT_IMP(a_eof_shape, tok_o.valid && tok_o.final_token, tok_o.token_kind == K_EOF && tok_o.token_length == '0, "final beat is not a zero-length eof")
  `STT_ASSERT_NXT(a_eot_reset, acc && eot, mode_q == M_IDLE && off_q == '0 && line_q == LINE_ONE, "scan state not cleared after end of text")
  `STT_ASSERT_NXT(a_off_step, acc && !eot && off_q != OFF_MAX, off_q == $past(off_q) + OFFSET_BITS'(1), "byte offset did not advance")
  `STT_ASSERT_IMP(a_line_nonzero, 1'b1, line_q != '0 && col_q != '0, "line or column reached zero")

endmodule
